// File: rtl/core/etfd_pkg.sv
// Shared constants and types for the edge-timed frame decoder.
package etfd_pkg;

    // Datapath sizes
    localparam int WORD_BITS   = 16;
    localparam int TIME_BITS   = 16;
    localparam int FRAME_WORDS = 10;
    localparam int SLOT_BITS   = 4;
    localparam int CFG_BITS    = 16;
    localparam int CFG_IDX_BITS = 2;
    localparam int OUT_WORD_BITS = 16;

    // Width used for the window comparisons
    localparam int CMP_BITS = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;

    // Word bit that restarts the slot count
    localparam int SLOT_RESTART_POS = 12;

    // Register reset values
    localparam logic [CFG_BITS-1:0] BIT_WINDOW_LOW_RST  = CFG_BITS'(75);
    localparam logic [CFG_BITS-1:0] BIT_WINDOW_HIGH_RST = CFG_BITS'(125);
    localparam logic [CFG_BITS-1:0] GAP_MIN_RST         = CFG_BITS'(6000);

    // Register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BIT_WINDOW_LOW  = 2'd0,
        CFG_BIT_WINDOW_HIGH = 2'd1,
        CFG_GAP_MIN         = 2'd2
    } cfg_idx_t;

    // Item kinds
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_EDGE = 1'b1;

    typedef logic [CMP_BITS-1:0] cmp_t;

    // One decoded result
    typedef struct packed {
        logic [OUT_WORD_BITS-1:0] word_value;
        logic [SLOT_BITS-1:0]     slot_number;
        logic                     frame_end;
        logic [4:0]               prog_value;
        logic [3:0]               prog_command;
        logic [2:0]               prog_address;
        logic [2:0]               ctrl_address;
        logic                     ctrl_lane_switch;
        logic [3:0]               ctrl_speed;
        logic [5:0]               pace_flags;
    } result_t;

endpackage

// File: rtl/core/edge_timed_frame_decoder.sv
// Top level of the edge-timed frame decoder.
// The decoder takes one request per clock cycle, ticks and edges alike, while
// s_ready is high. The timer, the shift word and the slot count are updated
// in the same cycle as the request, so back-to-back requests see each other's
// effect at once. A long-gap edge registers its word in the output register,
// or in the skid entry when the output is stalled: the input keeps flowing
// through one stalled result and only stops when a second result waits behind
// it. Configuration registers are written through a plain write port, by the
// user only while the decoder is idle; the block does not enforce this.
module edge_timed_frame_decoder (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration
    input  logic                                 cfg_wr_en,
    input  logic [etfd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [etfd_pkg::CFG_BITS-1:0]        cfg_wr_data,
    // request channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_func,
    input  logic                                 s_edge_rising,
    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [etfd_pkg::OUT_WORD_BITS-1:0]   m_word_value,
    output logic [etfd_pkg::SLOT_BITS-1:0]       m_slot_number,
    output logic                                 m_frame_end,
    output logic [4:0]                           m_prog_value,
    output logic [3:0]                           m_prog_command,
    output logic [2:0]                           m_prog_address,
    output logic [2:0]                           m_ctrl_address,
    output logic                                 m_ctrl_lane_switch,
    output logic [3:0]                           m_ctrl_speed,
    output logic [5:0]                           m_pace_flags
);
    import etfd_pkg::*;

    logic [CFG_BITS-1:0]  bit_low_reg, bit_high_reg, gap_min_reg;
    logic [TIME_BITS-1:0] elapsed_reg, elapsed_next;
    logic [WORD_BITS-1:0] shift_reg, shift_next;
    logic [SLOT_BITS-1:0] slot_reg, slot_next;

    result_t out_reg, skid_reg, res;
    logic    out_valid_reg, skid_valid_reg;

    logic                 accept, emit, in_bit_window, in_gap;
    logic [WORD_BITS-1:0] w;
    logic [SLOT_BITS-1:0] slot_base;
    logic [SLOT_BITS:0]   slot_inc;
    logic                 frame_end;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_low_reg  <= BIT_WINDOW_LOW_RST;
            bit_high_reg <= BIT_WINDOW_HIGH_RST;
            gap_min_reg  <= GAP_MIN_RST;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_BIT_WINDOW_LOW:  bit_low_reg  <= cfg_wr_data;
                CFG_BIT_WINDOW_HIGH: bit_high_reg <= cfg_wr_data;
                CFG_GAP_MIN:         gap_min_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Classify the edge against the bit window and the gap threshold
    assign in_bit_window = (cmp_t'(elapsed_reg) > cmp_t'(bit_low_reg))
                        && (cmp_t'(elapsed_reg) < cmp_t'(bit_high_reg));
    assign in_gap        = cmp_t'(elapsed_reg) > cmp_t'(gap_min_reg);

    // Slot numbering for an emitted word
    assign w         = shift_reg;
    assign slot_base = w[SLOT_RESTART_POS] ? '0 : slot_reg;
    assign slot_inc  = {1'b0, slot_base} + (SLOT_BITS+1)'(1);
    assign frame_end = slot_inc >= (SLOT_BITS+1)'(FRAME_WORDS);

    // Next state of the timer, the word and the slot count
    always_comb begin
        elapsed_next = elapsed_reg;
        shift_next   = shift_reg;
        slot_next    = slot_reg;
        emit         = 1'b0;
        if (accept) begin
            if (s_func == FUNC_TICK) begin
                if (elapsed_reg != '1) begin
                    elapsed_next = elapsed_reg + TIME_BITS'(1);
                end
            end else if (in_bit_window) begin
                shift_next   = {shift_reg[WORD_BITS-2:0], !s_edge_rising};
                elapsed_next = '0;
            end else if (in_gap) begin
                shift_next   = WORD_BITS'(1);
                elapsed_next = '0;
                slot_next    = frame_end ? '0 : slot_inc[SLOT_BITS-1:0];
                emit         = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elapsed_reg <= '0;
            shift_reg   <= '0;
            slot_reg    <= '0;
        end else begin
            elapsed_reg <= elapsed_next;
            shift_reg   <= shift_next;
            slot_reg    <= slot_next;
        end
    end

    // Unpack the fields of the finished word
    always_comb begin
        res.word_value       = w[OUT_WORD_BITS-1:0];
        res.slot_number      = slot_base;
        res.frame_end        = frame_end;
        res.prog_value       = {w[3], w[4], w[5], w[6], w[7]};
        res.prog_command     = {w[8], w[9], w[10], w[11]};
        res.prog_address     = {w[0], w[1], w[2]};
        res.ctrl_address     = w[8:6];
        res.ctrl_lane_switch = w[5];
        res.ctrl_speed       = w[4:1];
        res.pace_flags       = w[5:0];
    end

    // Output register with one skid entry behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= emit;
            end
        end else if (emit) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end else if (emit) begin
            skid_reg <= res;
        end
    end

    // Drive the result ports
    assign m_valid            = out_valid_reg;
    assign m_word_value       = out_reg.word_value;
    assign m_slot_number      = out_reg.slot_number;
    assign m_frame_end        = out_reg.frame_end;
    assign m_prog_value       = out_reg.prog_value;
    assign m_prog_command     = out_reg.prog_command;
    assign m_prog_address     = out_reg.prog_address;
    assign m_ctrl_address     = out_reg.ctrl_address;
    assign m_ctrl_lane_switch = out_reg.ctrl_lane_switch;
    assign m_ctrl_speed       = out_reg.ctrl_speed;
    assign m_pace_flags       = out_reg.pace_flags;

endmodule

// File: dv/frame_word_checker.sv
// Checker for the edge-timed frame decoder: predicts emitted words and compares them.
`timescale 1ns / 100ps

module frame_word_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [etfd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [etfd_pkg::CFG_BITS-1:0]       cfg_wr_data,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic                                s_func,
    input  logic                                s_edge_rising,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [etfd_pkg::OUT_WORD_BITS-1:0]  m_word_value,
    input  logic [etfd_pkg::SLOT_BITS-1:0]      m_slot_number,
    input  logic                                m_frame_end,
    input  logic [4:0]                          m_prog_value,
    input  logic [3:0]                          m_prog_command,
    input  logic [2:0]                          m_prog_address,
    input  logic [2:0]                          m_ctrl_address,
    input  logic                                m_ctrl_lane_switch,
    input  logic [3:0]                          m_ctrl_speed,
    input  logic [5:0]                          m_pace_flags,
    output int                                  fail_count,
    output int                                  words_waiting
);
    import etfd_pkg::*;

    // Predicted decoder state and register copies
    logic [TIME_BITS-1:0] since_edge_us;
    logic [WORD_BITS-1:0] assembled_bits;
    logic [SLOT_BITS-1:0] frame_slot;
    logic [CFG_BITS-1:0]  win_low_us;
    logic [CFG_BITS-1:0]  win_high_us;
    logic [CFG_BITS-1:0]  gap_us;

    result_t expected_words[$];
    int      mismatches = 0;

    // Advance the predicted decoder by one request; flag a finished word
    task automatic decode_request(input logic func, input logic rising,
                                  output bit emitted, output result_t word_out);
        logic [WORD_BITS-1:0]     w;
        logic [OUT_WORD_BITS-1:0] v;
        emitted  = 1'b0;
        word_out = '0;
        if (func == FUNC_TICK) begin
            // count up, hold at the top
            if (since_edge_us != '1)
                since_edge_us = since_edge_us + TIME_BITS'(1);
        end else if (since_edge_us > win_low_us && since_edge_us < win_high_us) begin
            // data edge: rising shifts in 0, falling shifts in 1
            assembled_bits = {assembled_bits[WORD_BITS-2:0], ~rising};
            since_edge_us  = '0;
        end else if (since_edge_us > gap_us) begin
            // long gap: emit the word and restart it at 1
            w              = assembled_bits;
            assembled_bits = WORD_BITS'(1);
            since_edge_us  = '0;
            if (w[SLOT_RESTART_POS])
                frame_slot = '0;
            word_out.slot_number = frame_slot;
            word_out.frame_end   = (int'(frame_slot) + 1 >= FRAME_WORDS);
            frame_slot = word_out.frame_end ? '0 : frame_slot + SLOT_BITS'(1);
            v = w[OUT_WORD_BITS-1:0];
            word_out.word_value       = v;
            word_out.prog_value       = {v[3], v[4], v[5], v[6], v[7]};
            word_out.prog_command     = {v[8], v[9], v[10], v[11]};
            word_out.prog_address     = {v[0], v[1], v[2]};
            word_out.ctrl_address     = v[8:6];
            word_out.ctrl_lane_switch = v[5];
            word_out.ctrl_speed       = v[4:1];
            word_out.pace_flags       = v[5:0];
            emitted = 1'b1;
        end
    endtask

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    // Track configuration, compare results, then predict from taken requests
    always @(posedge aclk) begin : track
        result_t want;
        result_t fresh;
        bit      emitted;
        if (!aresetn) begin
            since_edge_us  = '0;
            assembled_bits = '0;
            frame_slot     = '0;
            win_low_us     = BIT_WINDOW_LOW_RST;
            win_high_us    = BIT_WINDOW_HIGH_RST;
            gap_us         = GAP_MIN_RST;
            expected_words.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_BIT_WINDOW_LOW:  win_low_us  = cfg_wr_data;
                    CFG_BIT_WINDOW_HIGH: win_high_us = cfg_wr_data;
                    CFG_GAP_MIN:         gap_us      = cfg_wr_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected result word: got %0d", m_word_value);
                    mismatches++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("word_value", 32'(want.word_value), 32'(m_word_value));
                    check_field("slot_number", 32'(want.slot_number), 32'(m_slot_number));
                    check_field("frame_end", 32'(want.frame_end), 32'(m_frame_end));
                    check_field("prog_value", 32'(want.prog_value), 32'(m_prog_value));
                    check_field("prog_command", 32'(want.prog_command),
                                32'(m_prog_command));
                    check_field("prog_address", 32'(want.prog_address),
                                32'(m_prog_address));
                    check_field("ctrl_address", 32'(want.ctrl_address),
                                32'(m_ctrl_address));
                    check_field("ctrl_lane_switch", 32'(want.ctrl_lane_switch),
                                32'(m_ctrl_lane_switch));
                    check_field("ctrl_speed", 32'(want.ctrl_speed), 32'(m_ctrl_speed));
                    check_field("pace_flags", 32'(want.pace_flags), 32'(m_pace_flags));
                end
            end
            if (s_valid && s_ready) begin
                decode_request(s_func, s_edge_rising, emitted, fresh);
                if (emitted)
                    expected_words.push_back(fresh);
            end
        end
        fail_count    <= mismatches;
        words_waiting <= expected_words.size();
    end

endmodule

// File: dv/tb.sv
// Testbench top for the edge-timed frame decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;
    import etfd_pkg::*;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 8;
    localparam int STALL_LIMIT     = 5000;
    localparam int ITEM_TARGET     = 700;
    localparam int NUM_SETTINGS    = 6;

    logic                     aclk;
    logic                     aresetn       = 1'b0;
    logic                     cfg_wr_en     = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index     = CFG_BIT_WINDOW_LOW;
    logic [CFG_BITS-1:0]      cfg_wr_data   = '0;
    logic                     s_valid       = 1'b0;
    logic                     s_ready;
    logic                     s_func        = FUNC_TICK;
    logic                     s_edge_rising = 1'b0;
    logic                     m_valid;
    logic                     m_ready       = 1'b0;
    logic [OUT_WORD_BITS-1:0] m_word_value;
    logic [SLOT_BITS-1:0]     m_slot_number;
    logic                     m_frame_end;
    logic [4:0]               m_prog_value;
    logic [3:0]               m_prog_command;
    logic [2:0]               m_prog_address;
    logic [2:0]               m_ctrl_address;
    logic                     m_ctrl_lane_switch;
    logic [3:0]               m_ctrl_speed;
    logic [5:0]               m_pace_flags;

    int fail_count;
    int words_waiting;

    bit send_idling = 1'b1;
    bit recv_idling = 1'b1;
    int hold_offs_asked  = 0;
    int hold_offs_served = 0;
    int items_sent       = 0;
    int cur_low;
    int cur_high;
    int cur_gap;

    // Window settings visited by the random part: fast, wide, low edge at zero,
    // bit window over the gap window, closed bit window, and the extremes
    int set_low[NUM_SETTINGS]  = '{1, 2, 0, 0, 4, 65535};
    int set_high[NUM_SETTINGS] = '{3, 9, 6, 20, 5, 0};
    int set_gap[NUM_SETTINGS]  = '{3, 12, 6, 5, 8, 0};

    edge_timed_frame_decoder dut (.*);

    frame_word_checker word_check (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Mostly short gaps, a few long ones
    function automatic int idle_cycles(bit enabled);
        int r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one request and hold it until taken
    task automatic send_item(input logic func, input logic rising);
        int gap;
        gap = idle_cycles(send_idling);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_func        <= func;
        s_edge_rising <= rising;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic run_ticks(input int n);
        repeat (n) send_item(FUNC_TICK, 1'($urandom_range(0, 1)));
    endtask

    // Stop offering and wait until every predicted word has come out
    task automatic wait_for_words();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (words_waiting != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(input int low, input int high, input int gap);
        wait_for_words();
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_BIT_WINDOW_LOW;
        cfg_wr_data <= CFG_BITS'(low);
        @(posedge aclk);
        cfg_index   <= CFG_BIT_WINDOW_HIGH;
        cfg_wr_data <= CFG_BITS'(high);
        @(posedge aclk);
        cfg_index   <= CFG_GAP_MIN;
        cfg_wr_data <= CFG_BITS'(gap);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_low  = low;
        cur_high = high;
        cur_gap  = gap;
    endtask

    // Wait inside the bit window, then edge: falling for 1, rising for 0
    task automatic send_bit(input logic b);
        run_ticks($urandom_range(cur_low + 1, cur_high - 1));
        send_item(FUNC_EDGE, ~b);
    endtask

    // Wait past both windows, then edge to emit the word
    task automatic finish_word();
        int lim;
        lim = (cur_gap > cur_high - 1) ? cur_gap : cur_high - 1;
        run_ticks(lim + 1 + $urandom_range(0, 2));
        send_item(FUNC_EDGE, 1'($urandom_range(0, 1)));
    endtask

    // Shift in the low nbits of the pattern, MSB first, then emit
    task automatic send_word(input logic [31:0] pattern, input int nbits);
        if (cur_high >= cur_low + 2) begin
            for (int i = nbits - 1; i >= 0; i--)
                send_bit(pattern[i]);
        end
        finish_word();
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    initial begin
        int stall;
        forever begin
            @(posedge aclk);
            if (hold_offs_served != hold_offs_asked) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_offs_served++;
            end else begin
                stall = idle_cycles(recv_idling);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
        end
    end

    // Watchdog: end the run if nothing moves for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("edge_timed_frame_decoder test failed");
        $finish;
    end

    initial begin
        int p;
        int r;
        int nbits;
        int phase_end;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        cur_low  = 75;
        cur_high = 125;
        cur_gap  = 6000;

        // Reset windows: edge with no time elapsed, both window boundaries, gap boundary
        send_item(FUNC_EDGE, 1'b1);
        run_ticks(100);
        send_item(FUNC_EDGE, 1'b0);
        run_ticks(76);
        send_item(FUNC_EDGE, 1'b1);
        run_ticks(124);
        send_item(FUNC_EDGE, 1'b0);
        run_ticks(75);
        send_item(FUNC_EDGE, 1'b1);
        run_ticks(50);
        send_item(FUNC_EDGE, 1'b0);
        run_ticks(5875);
        send_item(FUNC_EDGE, 1'b1);
        run_ticks(1);
        send_item(FUNC_EDGE, 1'b1);

        // Slot restart, all-ones and all-zero words, frame wrap, overflow
        configure(1, 3, 3);
        send_word(32'h0000_0FFF, 12);
        send_word(32'hFFFF_FFFF, 16);
        send_word(32'h0000_0000, 16);
        repeat (10) send_word($urandom, $urandom_range(0, 11));
        send_word($urandom, 20);

        // Bit window overlapping the gap window: the bit wins
        configure(0, 20, 5);
        run_ticks(10);
        send_item(FUNC_EDGE, 1'b0);
        finish_word();

        // Saturate the timer, then widest and narrowest gap limits
        configure(0, 65535, 65535);
        send_idling = 1'b0;
        run_ticks(65540);
        send_item(FUNC_EDGE, 1'b0);
        configure(0, 65535, 65534);
        send_item(FUNC_EDGE, 1'b1);
        send_idling = 1'b1;
        configure(65535, 0, 0);
        send_item(FUNC_EDGE, 1'b0);
        run_ticks(1);
        send_item(FUNC_EDGE, 1'b1);

        // Random part, cycling through the window settings
        items_sent = 0;
        p = 0;
        while (items_sent < ITEM_TARGET) begin
            configure(set_low[p], set_high[p], set_gap[p]);
            send_idling = ($urandom_range(0, 3) != 0);
            recv_idling = ($urandom_range(0, 3) != 0);
            if (hold_offs_asked == 0) begin
                // hold the receiver off while words keep coming
                hold_offs_asked++;
                send_idling = 1'b0;
                repeat (8) send_word(0, 0);
            end
            phase_end = items_sent + 100;
            while (items_sent < phase_end) begin
                r = $urandom_range(0, 99);
                if (r < 72) begin
                    r = $urandom_range(0, 99);
                    nbits = (r < 70) ? $urandom_range(0, 11) :
                            (r < 90) ? $urandom_range(12, 16) : $urandom_range(17, 20);
                    send_word($urandom, nbits);
                end else if (r < 84) begin
                    repeat ($urandom_range(1, 8))
                        send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end else if (r < 94) begin
                    // stray edge at an arbitrary time
                    run_ticks($urandom_range(0, cur_gap + cur_high + 2));
                    send_item(FUNC_EDGE, 1'($urandom_range(0, 1)));
                end else begin
                    wait_for_words();
                end
            end
            p = (p + 1) % NUM_SETTINGS;
        end

        wait_for_words();
        if (fail_count == 0 && words_waiting == 0)
            $display("edge_timed_frame_decoder test passed");
        else
            $display("edge_timed_frame_decoder test failed");
        $finish;
    end

endmodule

// File: files.f
rtl/core/etfd_pkg.sv
rtl/core/edge_timed_frame_decoder.sv
dv/frame_word_checker.sv
dv/tb.sv
